// ===== design/comb_allpass_reverb_macros.svh =====
// Assertion macros used by the reverb top level.
`ifndef COMB_ALLPASS_REVERB_MACROS_SVH
`define COMB_ALLPASS_REVERB_MACROS_SVH
// Assert that a condition implies another in the same cycle.
`define CAR_ASSERT_IMPLY(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// Assert that a condition implies another in the next cycle.
`define CAR_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== design/car_pkg.sv =====
// Package: types and constants of the comb/allpass reverb.
package car_pkg;
    localparam int One16  = 65536;
    localparam int FbMax  = 65208;

    // configuration register indexes
    localparam logic [0:0] CfgSide  = 1'b0;
    localparam logic [0:0] CfgChaos = 1'b1;

    // comb lengths per side
    function automatic logic [11:0] comb_len(input logic side, input logic [1:0] k);
        logic [11:0] r;
        begin
            case ({side, k})
                3'd0: r = 12'd1557;
                3'd1: r = 12'd1617;
                3'd2: r = 12'd1491;
                3'd3: r = 12'd1422;
                3'd4: r = 12'd1277;
                3'd5: r = 12'd1356;
                3'd6: r = 12'd1188;
                default: r = 12'd1116;
            endcase
            return r;
        end
    endfunction

    function automatic logic [8:0] tap_room(input logic side, input logic k);
        logic [8:0] r;
        begin
            case ({side, k})
                2'd0: r = 9'd400;
                2'd1: r = 9'd350;
                2'd2: r = 9'd380;
                default: r = 9'd420;
            endcase
            return r;
        end
    endfunction

    function automatic logic [5:0] tap_chaos(input logic side, input logic k);
        logic [5:0] r;
        begin
            case ({side, k})
                2'd0: r = 6'd50;
                2'd1: r = 6'd40;
                2'd2: r = 6'd45;
                default: r = 6'd55;
            endcase
            return r;
        end
    endfunction

    function automatic logic [13:0] tap_gain(input logic side, input logic k);
        logic [13:0] r;
        begin
            case ({side, k})
                2'd0: r = 14'd9830;
                2'd1: r = 14'd7864;
                2'd2: r = 14'd8520;
                default: r = 14'd7209;
            endcase
            return r;
        end
    endfunction

    function automatic logic [9:0] ap_len(input logic [1:0] k);
        logic [9:0] r;
        begin
            case (k)
                2'd0: r = 10'd556;
                2'd1: r = 10'd441;
                2'd2: r = 10'd341;
                default: r = 10'd225;
            endcase
            return r;
        end
    endfunction

    function automatic logic [10:0] ap_base(input logic [1:0] k);
        logic [10:0] r;
        begin
            case (k)
                2'd0: r = 11'd0;
                2'd1: r = 11'd556;
                2'd2: r = 11'd997;
                default: r = 11'd1338;
            endcase
            return r;
        end
    endfunction

    // sequencer states, one-hot
    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_PREP   = 14'b00000000000100,
        ST_TAPOFF = 14'b00000000001000,
        ST_CRD    = 14'b00000000010000,
        ST_CLP    = 14'b00000000100000,
        ST_CMUL   = 14'b00000001000000,
        ST_CWR    = 14'b00000010000000,
        ST_TRD    = 14'b00000100000000,
        ST_TMUL   = 14'b00001000000000,
        ST_QUART  = 14'b00010000000000,
        ST_ARD    = 14'b00100000000000,
        ST_AWR    = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } state_t;
endpackage

// ===== design/comb_allpass_reverb.sv =====
// Top level: sequenced comb/allpass reverb around two delay memories.
//  channel | ports            | fields
//  input   | s_axis_t*        | left_in,right_in,room,damping,decay,chaos
//  output  | m_axis_t*        | reverb_out
//  config  | cfg_we/idx/data  | channel_side, chaos_enable
// After reset a clearing pass writes zero to every comb and allpass entry,
// during which no sample is accepted.
// The next sample is accepted only after this one has passed: accept, prep, 2 tap offsets,
// 4 comb passes of 4 (read, lowpass, multiply, write), 2 tap reads of 2, quarter,
// 4 allpass read/write pairs, output load.
// A result held by m_axis_tready stalls the next sample only at its output load.
module comb_allpass_reverb #(
    parameter int SAMPLE_WIDTH         = 24,
    parameter int COMB_REGION_DEPTH    = 2048,
    parameter int ALLPASS_REGION_DEPTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [SW-1:0] left_in, [2SW-1:SW] right_in, then room, damping, decay (17 each),
    // chaos_value (17, signed), zero padded
    input  logic [((2*SAMPLE_WIDTH+68+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [SW-1:0] reverb_out, zero padded
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int OW  = ((SW+7)/8)*8;
    localparam int CAW = $clog2(4*COMB_REGION_DEPTH);
    localparam int RAW = $clog2(COMB_REGION_DEPTH);
    localparam int AAW = $clog2(ALLPASS_REGION_DEPTH);
    localparam logic signed [SW+1:0] SMAX = (SW+2)'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [SW+1:0] SMIN = -(SW+2)'(64'sd1 <<< (SW-1));

    // saturate a 64-bit value to the sample range
    function automatic logic signed [SW-1:0] sat64(input logic signed [63:0] v);
        begin
            if (v > 64'(SMAX)) return SW'(SMAX);
            else if (v < 64'(SMIN)) return SW'(SMIN);
            else return v[SW-1:0];
        end
    endfunction

    // round half up by n bits (floor of v + half)
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        begin
            return (v + (64'sd1 <<< (n-1))) >>> n;
        end
    endfunction

    car_pkg::state_t state_reg, state_next;
    logic side_reg, chaos_en_reg;

    // input capture
    logic signed [SW-1:0] x_reg;
    logic [16:0]          room_reg, damp_k_reg, decay_reg;
    logic signed [16:0]   chaos_reg;
    logic [16:0]          fb_reg, damp_reg, scale_reg;
    logic signed [63:0]   feed_reg;
    logic [1:0]           k_reg;
    logic [11:0]          pos_reg [4];
    logic [11:0]          pe_reg  [4];
    logic [11:0]          tap_reg [2];
    logic signed [SW-1:0] lp_reg  [4];
    logic [9:0]           apos_reg [4];
    logic signed [SW+3:0] acc_reg;
    logic signed [63:0]   prod_reg;
    logic [13:0]          gain_reg;
    logic [CAW-1:0]       clr_reg;
    logic [SW-1:0]        out_reg;
    logic                 out_valid_reg;

    // memories
    logic           cm_we, am_we;
    logic [CAW-1:0] cm_waddr, cm_raddr;
    logic [SW-1:0]  cm_wdata, cm_rdata, am_wdata, am_rdata;
    logic [AAW-1:0] am_waddr, am_raddr;

    car_ram #(.DEPTH(4*COMB_REGION_DEPTH), .WIDTH(SW)) u_comb (
        .aclk(aclk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
        .raddr(cm_raddr), .rdata(cm_rdata));
    car_ram #(.DEPTH(ALLPASS_REGION_DEPTH), .WIDTH(SW)) u_ap (
        .aclk(aclk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata),
        .raddr(am_raddr), .rdata(am_rdata));

    // unpacked input fields
    logic signed [SW-1:0] in_l, in_r;
    logic [16:0] in_room, in_damp, in_decay, in_chaos;
    assign in_l     = s_axis_tdata[SW-1:0];
    assign in_r     = s_axis_tdata[2*SW-1:SW];
    assign in_room  = s_axis_tdata[2*SW+16:2*SW];
    assign in_damp  = s_axis_tdata[2*SW+33:2*SW+17];
    assign in_decay = s_axis_tdata[2*SW+50:2*SW+34];
    assign in_chaos = s_axis_tdata[2*SW+67:2*SW+51];

    // output register is free when empty or being taken this cycle
    logic out_free, out_stall;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    assign s_axis_tready = (state_reg == car_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(out_reg);

    logic s_fire, clr_done;
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign clr_done = (clr_reg == CAW'(4*COMB_REGION_DEPTH-1));

    // combinational helpers
    logic [11:0] len_k;
    logic [1:0]  ak;
    logic        tk;
    assign len_k = car_pkg::comb_len(side_reg, k_reg);
    assign ak    = k_reg;
    assign tk    = k_reg[0];

    logic signed [63:0] lp_new, tap_sum;
    logic [11:0] off_w, pnext;
    logic [9:0]  ap_p;
    always_comb begin
        lp_new  = 64'(sat64(64'(lp_reg[k_reg]) + rnd(prod_reg, 16)));
        tap_sum = 64'(room_reg) * 64'(car_pkg::tap_room(side_reg, tk))
                + 64'(chaos_reg) * 64'sd2 * 64'(car_pkg::tap_chaos(side_reg, tk));
        off_w   = (tap_sum > 0) ? 12'(tap_sum >>> 16) : 12'd0;
        if (off_w >= len_k) off_w = off_w - len_k;
        pnext   = (pe_reg[k_reg] + 12'd1 >= len_k) ? 12'd0 : pe_reg[k_reg] + 12'd1;
        ap_p    = (apos_reg[ak] >= car_pkg::ap_len(ak)) ? 10'd0 : apos_reg[ak];
    end

    // memory address and write steering
    always_comb begin
        cm_we    = 1'b0;
        cm_waddr = clr_reg;
        cm_wdata = '0;
        cm_raddr = CAW'({k_reg, RAW'(pe_reg[k_reg])});
        am_we    = 1'b0;
        am_waddr = clr_reg[AAW-1:0];
        am_wdata = '0;
        am_raddr = AAW'(car_pkg::ap_base(ak)) + AAW'(ap_p);
        case (state_reg)
            car_pkg::ST_CLEAR: begin
                cm_we = 1'b1;
                am_we = (clr_reg < CAW'(ALLPASS_REGION_DEPTH));
            end
            car_pkg::ST_CWR: begin
                cm_we    = 1'b1;
                cm_waddr = CAW'({k_reg, RAW'(pe_reg[k_reg])});
                cm_wdata = sat64(rnd(feed_reg + prod_reg, 16));
            end
            car_pkg::ST_TRD: cm_raddr = CAW'({k_reg, RAW'(tap_reg[tk])});
            car_pkg::ST_AWR: begin
                am_we    = 1'b1;
                am_waddr = am_raddr;
                am_wdata = sat64(64'(acc_reg) + rnd(64'($signed(am_rdata)), 1));
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            car_pkg::ST_CLEAR:  if (clr_done) state_next = car_pkg::ST_IDLE;
            car_pkg::ST_IDLE:   if (s_fire) state_next = car_pkg::ST_PREP;
            car_pkg::ST_PREP:   state_next = car_pkg::ST_TAPOFF;
            car_pkg::ST_TAPOFF: if (k_reg == 2'd1) state_next = car_pkg::ST_CRD;
            car_pkg::ST_CRD:    state_next = car_pkg::ST_CLP;
            car_pkg::ST_CLP:    state_next = car_pkg::ST_CMUL;
            car_pkg::ST_CMUL:   state_next = car_pkg::ST_CWR;
            car_pkg::ST_CWR:
                state_next = (k_reg == 2'd3) ? car_pkg::ST_TRD : car_pkg::ST_CRD;
            car_pkg::ST_TRD:    state_next = car_pkg::ST_TMUL;
            car_pkg::ST_TMUL:
                state_next = (k_reg == 2'd1) ? car_pkg::ST_QUART : car_pkg::ST_TRD;
            car_pkg::ST_QUART:  state_next = car_pkg::ST_ARD;
            car_pkg::ST_ARD:    state_next = car_pkg::ST_AWR;
            car_pkg::ST_AWR:
                state_next = (k_reg == 2'd3) ? car_pkg::ST_OUT : car_pkg::ST_ARD;
            car_pkg::ST_OUT:    if (out_free) state_next = car_pkg::ST_IDLE;
            default:            state_next = car_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= car_pkg::ST_CLEAR;
            clr_reg       <= '0;
            side_reg      <= 1'b0;
            chaos_en_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            for (int i = 0; i < 4; i++) begin
                pos_reg[i]  <= '0;
                lp_reg[i]   <= '0;
                apos_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == car_pkg::ST_CLEAR) clr_reg <= clr_reg + CAW'(1);
            if (cfg_we && cfg_index == car_pkg::CfgSide)  side_reg     <= cfg_data[0];
            if (cfg_we && cfg_index == car_pkg::CfgChaos) chaos_en_reg <= cfg_data[0];
            if (state_reg == car_pkg::ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                car_pkg::ST_PREP: k_reg <= '0;
                car_pkg::ST_TAPOFF: k_reg <= (k_reg == 2'd1) ? 2'd0 : k_reg + 2'd1;
                car_pkg::ST_CMUL: lp_reg[k_reg] <= lp_new[SW-1:0];
                car_pkg::ST_CWR: begin
                    pos_reg[k_reg] <= pnext;
                    k_reg <= k_reg + 2'd1;
                end
                car_pkg::ST_TMUL:
                    k_reg <= (k_reg == 2'd1) ? 2'd0 : k_reg + 2'd1;
                car_pkg::ST_AWR: begin
                    apos_reg[ak] <= (ap_p + 10'd1 >= car_pkg::ap_len(ak)) ? 10'd0
                                                                         : ap_p + 10'd1;
                    k_reg <= k_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            car_pkg::ST_IDLE: if (s_fire) begin
                x_reg      <= side_reg ? in_r : in_l;
                room_reg   <= (in_room  > 17'(car_pkg::One16)) ? 17'(car_pkg::One16) : in_room;
                damp_k_reg <= (in_damp  > 17'(car_pkg::One16)) ? 17'(car_pkg::One16) : in_damp;
                decay_reg  <= (in_decay > 17'(car_pkg::One16)) ? 17'(car_pkg::One16) : in_decay;
                chaos_reg  <= ($signed(in_chaos) > 17'sd32767) ? 17'sd32767 + 17'sd1 - 17'sd0 :
                              ($signed(in_chaos) < -17'sd32768) ? -17'sd32768 : $signed(in_chaos);
            end
            car_pkg::ST_PREP: begin
                logic signed [20:0] fbv;
                fbv = 21'sd32768 + 21'(rnd(64'(decay_reg) * 64'sd31785, 16));
                if (chaos_en_reg) begin
                    fbv = fbv + 21'(chaos_reg);
                    if (fbv < 0) fbv = '0;
                    if (fbv > 21'sd65208) fbv = 21'sd65208;
                end
                fb_reg    <= 17'(fbv);
                damp_reg  <= 17'(3277 + rnd(64'(damp_k_reg) * 64'sd58982, 16));
                scale_reg <= 17'(19661 + rnd(64'(room_reg) * 64'sd91750, 16));
                acc_reg   <= '0;
                for (int i = 0; i < 4; i++) begin
                    logic [11:0] l, p;
                    l = car_pkg::comb_len(side_reg, 2'(i));
                    p = pos_reg[i];
                    if (p >= l) p = p - l;
                    if (p >= l) p = '0;
                    pe_reg[i] <= p;
                end
            end
            car_pkg::ST_TAPOFF: begin
                tap_reg[tk] <= (pe_reg[k_reg] >= off_w) ? pe_reg[k_reg] - off_w
                                                       : pe_reg[k_reg] + len_k - off_w;
                feed_reg    <= 64'(x_reg) * 64'(scale_reg);
            end
            car_pkg::ST_CLP: begin
                prod_reg <= (64'($signed(cm_rdata)) - 64'(lp_reg[k_reg])) * 64'(damp_reg);
                acc_reg  <= acc_reg + (SW+4)'($signed(cm_rdata));
            end
            car_pkg::ST_CMUL: prod_reg <= lp_new * 64'(fb_reg);
            // tap gain ready while the tap entry is read
            car_pkg::ST_TRD:
                gain_reg <= 14'(rnd(64'(room_reg) * 64'(car_pkg::tap_gain(side_reg, tk)), 16));
            car_pkg::ST_TMUL: acc_reg <= acc_reg + (SW+4)'(rnd(64'($signed(cm_rdata)) *
                64'(gain_reg), 16));
            car_pkg::ST_QUART: acc_reg <= (SW+4)'(sat64(rnd(64'(acc_reg), 2)));
            car_pkg::ST_AWR: acc_reg <= (SW+4)'(sat64(64'($signed(am_rdata))
                                                       - rnd(64'(acc_reg), 1)));
            car_pkg::ST_OUT: if (out_free) out_reg <= acc_reg[SW-1:0];
            default: ;
        endcase
    end

`include "comb_allpass_reverb_macros.svh"
    `CAR_ASSERT_IMPLY(a_no_accept_busy, aclk, aresetn, s_axis_tready, state_reg == car_pkg::ST_IDLE)
    `CAR_ASSERT_NEXT(a_out_follows, aclk, aresetn, state_reg == car_pkg::ST_OUT, m_axis_tvalid)
    `CAR_ASSERT_IMPLY(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg))
    `CAR_ASSERT_NEXT(a_valid_hold, aclk, aresetn, out_stall, m_axis_tvalid)
    `CAR_ASSERT_NEXT(a_data_hold, aclk, aresetn, out_stall, $stable(m_axis_tdata))
endmodule

// ===== design/car_ram.sv =====
// Single-port-write, registered-read memory used for delay lines.
module car_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port, registered read; reading the entry being written returns the old value
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
